// ===== rtl/core/box_filter_3x3_rgb_unit_assert.svh =====
// Assertion macros for the box filter unit.
`ifndef BOX_FILTER_3X3_RGB_UNIT_ASSERT_SVH
`define BOX_FILTER_3X3_RGB_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define BF3_ASSERT_COMB(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("box filter check failed");
`define BF3_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box filter sequence check failed");
`else
`define BF3_ASSERT_COMB(lbl, prop)
`define BF3_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/bf3_pkg.sv =====
`default_nettype none

package bf3_pkg;

    localparam int BF3_MAX_WIDTH = 4096;
    localparam int NUM_CHAN      = 3;
    localparam int WIDTH_BITS    = 13;
    localparam int HEIGHT_BITS   = 16;
    localparam int CFG_ADDR_BITS = 1;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 13'd640;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;

    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // floor(x/9) == (x*7282) >> 16 for every x up to 2299
    localparam logic [12:0] DIV9_MUL   = 13'd7282;
    localparam int          DIV9_SHIFT = 16;

    typedef logic [7:0]        sample_t;
    typedef sample_t [2:0]     pix_t;
    typedef pix_t [8:0]        win_t;
    typedef sample_t [8:0]     taps_t;

    typedef struct packed {
        logic emit;
        logic last;
    } pos_t;

    typedef struct packed {
        logic sum_load;
        logic quo_load;
    } lane_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/bf3_raster.sv =====
`default_nettype none

module bf3_raster
    import bf3_pkg::*;
#(
    parameter int MAX_WIDTH = BF3_MAX_WIDTH,
    localparam int CW = $clog2(MAX_WIDTH)
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                     advance,
    output logic      [CW-1:0]            col,
    output pos_t                          pos
);

    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [CW-1:0]          col_reg;
    logic [CW-1:0]          col_next;
    logic [HEIGHT_BITS-1:0] row_reg;
    logic [HEIGHT_BITS-1:0] row_next;
    logic [CW-1:0]          last_col;
    logic [HEIGHT_BITS-1:0] last_row;
    logic                   col_wrap;
    logic                   row_wrap;

    always_comb
    begin
        priority if (width_reg < 13'd3)
        begin
            last_col = CW'(2);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            last_col = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = CW'(width_reg - 13'd1);
        end

        if (height_reg < 16'd3)
        begin
            last_row = 16'd2;
        end
        else
        begin
            last_row = height_reg - 16'd1;
        end

        col_wrap = (col_reg >= last_col);
        row_wrap = (row_reg >= last_row);

        if (col_wrap)
        begin
            col_next = '0;
            row_next = row_wrap ? '0 : row_reg + 16'd1;
        end
        else
        begin
            col_next = col_reg + CW'(1);
            row_next = row_reg;
        end
    end

    assign col      = col_reg;
    assign pos.emit = (col_reg >= CW'(2)) && (row_reg >= 16'd2);
    assign pos.last = col_wrap && row_wrap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            if (cfg_we && cfg_addr == REG_IMAGE_WIDTH)
            begin
                width_reg <= cfg_data[WIDTH_BITS-1:0];
            end
            if (cfg_we && cfg_addr == REG_IMAGE_HEIGHT)
            begin
                height_reg <= cfg_data[HEIGHT_BITS-1:0];
            end
            if (advance)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bf3_line_buf.sv =====
`default_nettype none

module bf3_line_buf
    import bf3_pkg::*;
#(
    parameter int MAX_WIDTH = BF3_MAX_WIDTH,
    localparam int CW = $clog2(MAX_WIDTH)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire logic          shift,
    input  wire pix_t          pix,
    input  wire logic [CW-1:0] idx,
    output win_t               win_next,
    output logic      [CW-1:0] hold_idx
);

    pix_t          upper_mem [0:MAX_WIDTH-1];
    pix_t          lower_mem [0:MAX_WIDTH-1];
    pix_t          top_reg;
    pix_t          mid_reg;
    pix_t          pix_reg;
    logic [CW-1:0] idx_reg;
    win_t          win_reg;

    // read old rows and store the new pixel; the upper row is written when the window shifts
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            top_reg        <= upper_mem[idx];
            mid_reg        <= lower_mem[idx];
            lower_mem[idx] <= pix;
            pix_reg        <= pix;
            idx_reg        <= idx;
        end
        if (shift)
        begin
            upper_mem[idx_reg] <= mid_reg;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3]     = win_reg[r*3 + 1];
            win_next[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_next[2] = top_reg;
        win_next[5] = mid_reg;
        win_next[8] = pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (shift)
        begin
            win_reg <= win_next;
        end
    end

    assign hold_idx = idx_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bf3_lane.sv =====
`default_nettype none

module bf3_lane
    import bf3_pkg::*;
(
    input  wire logic      clk,
    input  wire lane_ctl_t ctl,
    input  wire taps_t     taps,
    output sample_t        mean
);

    logic [9:0]  col_a;
    logic [9:0]  col_b;
    logic [9:0]  col_c;
    logic [11:0] sum_next;
    logic [11:0] sum_reg;
    logic [24:0] prod;
    sample_t     quo_reg;

    always_comb
    begin
        col_a    = 10'(taps[0]) + 10'(taps[3]) + 10'(taps[6]);
        col_b    = 10'(taps[1]) + 10'(taps[4]) + 10'(taps[7]);
        col_c    = 10'(taps[2]) + 10'(taps[5]) + 10'(taps[8]);
        // bias by 4 to round to nearest
        sum_next = 12'(col_a) + 12'(col_b) + 12'(col_c) + 12'd4;
        prod     = 25'(sum_reg) * 25'(DIV9_MUL);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sum_load)
        begin
            sum_reg <= sum_next;
        end
        if (ctl.quo_load)
        begin
            quo_reg <= prod[DIV9_SHIFT +: 8];
        end
    end

    assign mean = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/box_filter_3x3_rgb_unit.sv =====
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata: red, green, blue
// m_axis    out  tvalid/tready          tdata: red, green, blue; tlast: frame end
// cfg       in   cfg_we (no wait)       cfg_addr: register index, cfg_data: value
//
// One pixel per clock sustained while m_axis_tready is high.
// Rate is set by the line stores: one read and one write per store per cycle.
// Pipeline: line store read, 3x3 sum per lane, multiply-by-reciprocal divide.
// Reset clears counters, window and stage valids; line stores are not cleared.
// A stalled output fills the pipeline bubbles first, then holds s_axis_tready low.
`default_nettype none

`include "box_filter_3x3_rgb_unit_assert.svh"

module box_filter_3x3_rgb_unit
    import bf3_pkg::*;
#(
    parameter int MAX_WIDTH = BF3_MAX_WIDTH
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [23:0]              s_axis_tdata,   // red_in, green_in, blue_in
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic      [23:0]              m_axis_tdata,   // red_out, green_out, blue_out
    output logic                          m_axis_tlast,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic          accept;
    logic [CW-1:0] col;
    logic [CW-1:0] hold_idx;
    pos_t          pos;
    win_t          win_next;
    pix_t          means;
    lane_ctl_t     lane_ctl;

    logic          s1_valid_reg;
    pos_t          s1_pos_reg;
    logic          s2_valid_reg;
    logic          s2_last_reg;
    logic          s3_valid_reg;
    logic          s3_last_reg;
    logic          s1_adv;
    logic          s2_ready;
    logic          s3_ready;

    assign s3_ready          = !s3_valid_reg || m_axis_tready;
    assign s2_ready          = !s2_valid_reg || s3_ready;
    assign s1_adv            = s1_valid_reg && (!s1_pos_reg.emit || s2_ready);
    assign s_axis_tready     = !s1_valid_reg || s1_adv;
    assign accept            = s_axis_tvalid && s_axis_tready;
    assign lane_ctl.sum_load = s1_adv && s1_pos_reg.emit;
    assign lane_ctl.quo_load = s2_valid_reg && s3_ready;

    bf3_raster #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_raster (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .advance  (accept),
        .col      (col),
        .pos      (pos)
    );

    bf3_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .shift    (s1_adv),
        .pix      (s_axis_tdata),
        .idx      (col),
        .win_next (win_next),
        .hold_idx (hold_idx)
    );

    for (genvar ch = 0; ch < NUM_CHAN; ch++)
    begin : g_lane
        taps_t taps;

        always_comb
        begin
            for (int k = 0; k < 9; k++)
            begin
                taps[k] = win_next[k][ch];
            end
        end

        bf3_lane u_lane (
            .clk  (clk),
            .ctl  (lane_ctl),
            .taps (taps),
            .mean (means[ch])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_pos_reg   <= '0;
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            s3_valid_reg <= 1'b0;
            s3_last_reg  <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (accept)
            begin
                s1_pos_reg <= pos;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= lane_ctl.sum_load;
                s2_last_reg  <= s1_pos_reg.last;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
                s3_last_reg  <= s2_last_reg;
            end
        end
    end

    assign m_axis_tvalid = s3_valid_reg;
    assign m_axis_tlast  = s3_last_reg;
    assign m_axis_tdata  = means;

    `BF3_ASSERT_COMB(a_addr_distinct, (accept && s1_valid_reg) |-> (col != hold_idx))
    `BF3_ASSERT_COMB(a_last_emits, (s1_valid_reg && s1_pos_reg.last) |-> s1_pos_reg.emit)
    `BF3_ASSERT_NEXT(a_frame_wrap, accept && pos.last, col == '0 && !pos.emit)

endmodule

`default_nettype wire
